/* rtl/uvq_pkg.sv */
// Types and codes shared by the unique value queue core.
// Holds the word structs, the status and operation codes and the state encoding.
// No dependencies.
`default_nettype none

package uvq_pkg;

  localparam int unsigned VALUE_W = 31;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NEGATIVE  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_REMOVE,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value_in;
  } in_word_t;

  typedef struct packed {
    status_e              status;
    logic [VALUE_W-1:0]   value_out;
  } out_word_t;

endpackage : uvq_pkg

`default_nettype wire

/* rtl/unique_value_fifo_queue_core.sv */
// Unique value FIFO queue core: entry memory, duplicate scan sequencer, output register.
// Depends on uvq_pkg for word structs, status codes and state encoding.
//
//   channel | signals                          | word
//   --------+----------------------------------+------------------------------
//   in      | in_valid_i  in_ready_o in_data_i   | in_word_t  (op, value_in)
//   out     | out_valid_o out_ready_i out_data_o | out_word_t (status, value_out)
//
// One word is processed at a time. An insert into a queue holding n entries reads
// the entry memory once per cycle, one held entry each, and stops early when a
// duplicate turns up. A negative value or any word on an empty queue reads no entry;
// a remove from a non-empty queue waits for the registered memory read.
// Reset clears the read and write indices, the fill count, the scan counters, the
// state and the valid flags; the memory, the scan index and data registers are not.
// A new word is taken while the previous result waits in the output register; the
// next result then holds in its done state until the output register is free.
`default_nettype none

module unique_value_fifo_queue_core
  import uvq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  endfunction

  fsm_e               state_q, state_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]   scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic [CNT_W-1:0]   cmp_q, cmp_d;
  logic               rd_vld_q, rd_vld_d;
  out_word_t          res_q, res_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  logic [VALUE_W-1:0] mem [QUEUE_DEPTH];
  logic [VALUE_W-1:0] rd_data_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    fill_d      = fill_q;
    scan_idx_d  = scan_idx_q;
    iss_d       = iss_q;
    cmp_d       = cmp_q;
    rd_vld_d    = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = scan_idx_q;
    wr_en       = 1'b0;
    wr_addr     = wr_idx_q;
    wr_data     = val_q;
    in_ready_o  = (state_q == FSM_IDLE);

    // drop the delivered word
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          val_d = in_data_i.value_in[VALUE_W-1:0];
          if (in_data_i.op == OP_INSERT) begin
            if (in_data_i.value_in[31]) begin
              res_d   = '{status: ST_NEGATIVE, value_out: '0};
              state_d = FSM_DONE;
            end else if (fill_q == '0) begin
              wr_en    = 1'b1;
              wr_data  = in_data_i.value_in[VALUE_W-1:0];
              wr_idx_d = next_idx(wr_idx_q);
              fill_d   = fill_q + CNT_W'(1);
              res_d    = '{status: ST_OK, value_out: in_data_i.value_in[VALUE_W-1:0]};
              state_d  = FSM_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = rd_idx_q;
              rd_vld_d   = 1'b1;
              scan_idx_d = next_idx(rd_idx_q);
              iss_d      = CNT_W'(1);
              cmp_d      = '0;
              state_d    = FSM_SCAN;
            end
          end else begin
            if (fill_q == '0) begin
              res_d   = '{status: ST_EMPTY, value_out: '0};
              state_d = FSM_DONE;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = rd_idx_q;
              rd_vld_d = 1'b1;
              state_d  = FSM_REMOVE;
            end
          end
        end
      end

      FSM_SCAN: begin
        // keep one read in flight per cycle until every held entry is issued
        if (iss_q < fill_q) begin
          rd_en      = 1'b1;
          rd_addr    = scan_idx_q;
          rd_vld_d   = 1'b1;
          scan_idx_d = next_idx(scan_idx_q);
          iss_d      = iss_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          if (rd_data_q == val_q) begin
            res_d   = '{status: ST_DUPLICATE, value_out: '0};
            state_d = FSM_DONE;
          end else if (cmp_q + CNT_W'(1) == fill_q) begin
            if (fill_q == FULL_CNT) begin
              res_d = '{status: ST_FULL, value_out: '0};
            end else begin
              wr_en    = 1'b1;
              wr_idx_d = next_idx(wr_idx_q);
              fill_d   = fill_q + CNT_W'(1);
              res_d    = '{status: ST_OK, value_out: val_q};
            end
            state_d = FSM_DONE;
          end else begin
            cmp_d = cmp_q + CNT_W'(1);
          end
        end
      end

      FSM_REMOVE: begin
        res_d    = '{status: ST_OK, value_out: rd_data_q};
        rd_idx_d = next_idx(rd_idx_q);
        fill_d   = fill_q - CNT_W'(1);
        state_d  = FSM_DONE;
      end

      FSM_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      fill_q      <= '0;
      iss_q       <= '0;
      cmp_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      fill_q      <= fill_d;
      iss_q       <= iss_d;
      cmp_q       <= cmp_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    scan_idx_q <= scan_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count above queue depth");

  a_idx_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == FULL_CNT) |-> (rd_idx_q == wr_idx_q))
    else $error("indices disagree with fill count");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> (out_data_o.value_out == '0))
    else $error("error word carries a value");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SCAN) |-> (cmp_q < fill_q && iss_q <= fill_q))
    else $error("scan counters out of range");

endmodule : unique_value_fifo_queue_core

`default_nettype wire

/* tb/sv/tb_unique_value_fifo_queue_core.sv */
`timescale 1ns / 100ps
// Self-checking bench for unique_value_fifo_queue_core: directed then random insert/remove words.
// Predicts every result word from its own copy of the queue. Depends on uvq_pkg and the core.

module tb_unique_value_fifo_queue_core
  import uvq_pkg::*;
();

  localparam int unsigned DEPTH      = 16;
  localparam int          RAND_WORDS = 1300;
  localparam int          TAIL_WORDS = 200;
  localparam int          POOL_SIZE  = 24;
  localparam int          MAX_SHOWN  = 10;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  in_word_t  ops_to_send[$];
  out_word_t results_due[$];

  // own copy of the queue contents
  logic [VALUE_W-1:0] held_vals [DEPTH];
  int unsigned        head_idx;
  int unsigned        tail_idx;
  int unsigned        held_cnt;

  logic [VALUE_W-1:0] value_pool [POOL_SIZE];
  int unsigned        words_taken  = 0;
  int unsigned        mismatch_cnt = 0;
  int unsigned        send_idle;
  int unsigned        recv_idle;

  unique_value_fifo_queue_core #(
    .QUEUE_DEPTH (DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one word to the queue copy and return the result word it yields.
  function automatic out_word_t apply_queue_op(in_word_t w);
    out_word_t          r;
    logic [VALUE_W-1:0] v;
    int unsigned        idx;
    int unsigned        k;
    logic               dup;
    r.status    = ST_OK;
    r.value_out = '0;
    v           = w.value_in[VALUE_W-1:0];
    if (w.op == OP_INSERT) begin
      dup = 1'b0;
      idx = head_idx;
      for (k = 0; k < held_cnt; k++) begin
        if (held_vals[idx] == v) dup = 1'b1;
        idx = (idx + 1) % DEPTH;
      end
      // negative beats duplicate, duplicate beats full
      if (w.value_in[31]) begin
        r.status = ST_NEGATIVE;
      end else if (dup) begin
        r.status = ST_DUPLICATE;
      end else if (held_cnt >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_vals[tail_idx] = v;
        tail_idx            = (tail_idx + 1) % DEPTH;
        held_cnt++;
        r.value_out = v;
      end
    end else begin
      if (held_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value_out = held_vals[head_idx];
        head_idx    = (head_idx + 1) % DEPTH;
        held_cnt--;
      end
    end
    return r;
  endfunction

  // No idling in the tail of the run, nor in one stretch out of every four.
  function automatic logic no_idling();
    return (ops_to_send.size() < TAIL_WORDS) || (((words_taken / 150) % 4) == 2);
  endfunction

  task automatic add_op(op_e op, logic [31:0] val);
    in_word_t w;
    w.op       = op;
    w.value_in = val;
    ops_to_send.push_back(w);
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatch_cnt < MAX_SHOWN)
      $display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
    mismatch_cnt++;
  endtask

  // Sender: hold each word until taken, then maybe pause for a burst.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      send_idle <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_idle != 0) begin
        in_valid  <= 1'b0;
        send_idle <= send_idle - 1;
      end else if (ops_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= ops_to_send.pop_front();
        if (!no_idling() && $urandom_range(0, 5) == 0) send_idle <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: now and then stall out_ready for a random burst.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_idle <= 0;
    end else if (recv_idle != 0) begin
      out_ready <= 1'b0;
      recv_idle <= recv_idle - 1;
    end else if (!no_idling() && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      recv_idle <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check result words first, then predict for the word taken at the same edge.
  always @(posedge clk_i) begin : mon
    out_word_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          note_mismatch("unexpected word", '0, 32'(out_data));
        end else begin
          want = results_due.pop_front();
          if (out_data.status != want.status)
            note_mismatch("status", 32'(want.status), 32'(out_data.status));
          if (out_data.value_out != want.value_out)
            note_mismatch("value_out", 32'(want.value_out), 32'(out_data.value_out));
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(apply_queue_op(in_data));
        words_taken <= words_taken + 1;
      end
    end
  end

  initial begin
    int          n;
    int          j;
    int          k;
    int          seg_len;
    int          insert_pct;
    logic [31:0] val;

    head_idx = 0;
    tail_idx = 0;
    held_cnt = 0;
    for (k = 0; k < POOL_SIZE; k++)
      value_pool[k] = (k < 12) ? VALUE_W'(k) : VALUE_W'($urandom);
    value_pool[12] = '1;

    // directed: empty remove, field extremes, negatives, duplicates, wrap, full
    add_op(OP_REMOVE, 32'hFFFF_FFFF);
    add_op(OP_INSERT, 32'h0000_0000);
    add_op(OP_INSERT, 32'h7FFF_FFFF);
    add_op(OP_INSERT, 32'h8000_0000);
    add_op(OP_INSERT, 32'hFFFF_FFFF);
    add_op(OP_INSERT, 32'h0000_0000);
    add_op(OP_REMOVE, 32'h0000_1234);
    add_op(OP_REMOVE, 32'h8000_0000);
    add_op(OP_REMOVE, 32'h0000_0000);
    for (k = 0; k < DEPTH; k++)
      add_op(OP_INSERT, (32'h1 << k) | 32'(k));
    add_op(OP_INSERT, 32'h4000_0000);
    add_op(OP_INSERT, 32'h0000_0001);
    add_op(OP_INSERT, 32'hC000_0001);

    // random: segments that lean towards filling, draining or neither
    n = 0;
    while (n < RAND_WORDS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 80;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      for (j = 0; j < seg_len && n < RAND_WORDS; j++) begin
        if ($urandom_range(1, 100) <= insert_pct) begin
          case ($urandom_range(0, 9))
            0:       val = $urandom;
            1:       val = $urandom | 32'h8000_0000;
            2:       val = $urandom & 32'h7FFF_FFFF;
            default: val = {1'b0, value_pool[$urandom_range(0, POOL_SIZE - 1)]};
          endcase
          add_op(OP_INSERT, val);
        end else begin
          add_op(OP_REMOVE, $urandom);
        end
        n++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    // let a late stray word show up
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/uvq_pkg.sv
rtl/unique_value_fifo_queue_core.sv
tb/sv/tb_unique_value_fifo_queue_core.sv
